[rtl/cpwm_pkg.sv]
// shared constants, types and register codes for the sine current loop
`default_nettype none

package cpwm_pkg;

  // inverter timing
  localparam int SAMPLES_PER_CYCLE = 400;
  localparam int COMPARE_MAX       = 4500;
  localparam int HALF_CMP          = COMPARE_MAX / 2;

  // phase and angle tracking (angle is a 16-bit fraction of a turn)
  localparam int PHASE_W  = 12;
  localparam int ANG_W    = 16;
  localparam int REM_W    = 12;
  localparam int ANG_STEP = 65536 / SAMPLES_PER_CYCLE;
  localparam int ANG_REM  = 65536 % SAMPLES_PER_CYCLE;

  // quarter-wave polynomial, q15
  localparam int SIN_A     = 51472;
  localparam int SIN_B     = 21024;
  localparam int SIN_C     = 2320;
  localparam int SQRT2_Q15 = 46341;

  // field widths
  localparam int MEAS_W     = 16;
  localparam int REF_W      = 16;
  localparam int CMP_W      = 13;
  localparam int AMP_W      = 15;
  localparam int GAIN_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // correction clamp, counts scaled by 2048
  localparam int                LIM_W     = 29;
  localparam logic [LIM_W-1:0]  CLAMP_LIM = LIM_W'(HALF_CMP * 2048);
  localparam logic [CMP_W-1:0]  CMP_HI    = CMP_W'((2 * HALF_CMP) % 8192);
  localparam logic [CMP_W-1:0]  CMP_TOP   = (COMPARE_MAX > 8191) ? CMP_W'(8191)
                                                                 : CMP_W'(2 * HALF_CMP);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RST = 12'd800;

  // serial multiplier geometry
  localparam int MUL_A_W   = 30;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int MUL_CNT_W = 5;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

[rtl/cpwm_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module cpwm_mul import cpwm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_P_W-1:0]   p_q, p_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [MUL_A_W:0]     sum;

  // add the multiplicand into the upper half when the low bit is set, then shift
  always_comb begin
    sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + {1'b0, (p_q[0] ? a_q : '0)};
    p_d = {sum, p_q[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= MUL_CNT_W'(MUL_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{MUL_A_W{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = p_q;

endmodule

`default_nettype wire

[rtl/cpwm_phase.sv]
// phase index and sine angle tracker, angle kept by quotient and remainder steps
`default_nettype none

module cpwm_phase import cpwm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  output logic      [ANG_W-1:0] angle_o
);

  logic [PHASE_W-1:0] idx_q, idx_d;
  logic [ANG_W-1:0]   ang_q, ang_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [REM_W:0]     rem_sum, rem_red;
  logic               carry, wrap;

  always_comb begin
    rem_sum = {1'b0, rem_q} + (REM_W+1)'(ANG_REM);
    rem_red = rem_sum - (REM_W+1)'(SAMPLES_PER_CYCLE);
    carry   = rem_sum >= (REM_W+1)'(SAMPLES_PER_CYCLE);
    wrap    = idx_q == PHASE_W'(SAMPLES_PER_CYCLE - 1);
    if (wrap) begin
      idx_d = '0;
      ang_d = '0;
      rem_d = '0;
    end else begin
      idx_d = idx_q + 1'b1;
      ang_d = ang_q + ANG_W'(ANG_STEP) + {{(ANG_W-1){1'b0}}, carry};
      rem_d = carry ? rem_red[REM_W-1:0] : rem_sum[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ang_q <= '0;
      rem_q <= '0;
    end else if (adv_i) begin
      idx_q <= idx_d;
      ang_q <= ang_d;
      rem_q <= rem_d;
    end
  end

  assign angle_o = ang_q;

endmodule

`default_nettype wire

[rtl/sine_ref_current_loop_pwm.sv]
// top level: sine reference current loop producing a pwm compare value
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   measured_current_i
//   out       output     out_valid_o / out_ready_i compare_value_o, reference_current_o,
//                                                  drive_saturated_o
//   cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// one beat in gives one beat out, loaded into the output register once that register is free
// seven products go one after the other through one bit-serial multiplier
// a new beat is taken only after the previous result has been loaded into the output register
// a finished result waits in the output register; the next beat can start meanwhile
// reset clears the phase to zero, amplitude to zero and gain to its default
`default_nettype none

module sine_ref_current_loop_pwm import cpwm_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // sample input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [MEAS_W-1:0]     measured_current_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic             [CMP_W-1:0]      compare_value_o,
  output logic signed      [REF_W-1:0]      reference_current_o,
  output logic                              drive_saturated_o,
  // register writes
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ZSQ  = 4'd1;  // z * z
  localparam logic [3:0] S_CZ   = 4'd2;  // c * z2
  localparam logic [3:0] S_IZ   = 4'd3;  // inner * z2
  localparam logic [3:0] S_MZ   = 4'd4;  // mid * z
  localparam logic [3:0] S_SA   = 4'd5;  // |sine| * amplitude
  localparam logic [3:0] S_RT2  = 4'd6;  // times sqrt2
  localparam logic [3:0] S_DIFF = 4'd7;  // error and its magnitude
  localparam logic [3:0] S_GAIN = 4'd8;  // |error| * gain
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [AMP_W-1:0]  amp_q;
  logic [GAIN_W-1:0] gain_q;

  // working registers
  logic signed [MEAS_W-1:0] meas_q, meas_d;
  logic                     sneg_q, sneg_d;    // sine negative half
  logic [14:0]              z_q, z_d;
  logic [14:0]              z2_q, z2_d;
  logic signed [REF_W-1:0]  ref_q, ref_d;
  logic                     dneg_q, dneg_d;    // error negative
  logic [CMP_W-1:0]         cmp_q, cmp_d;
  logic                     sat_q, sat_d;

  // output register
  logic                     ov_q;
  logic [CMP_W-1:0]         cv_q;
  logic signed [REF_W-1:0]  rc_q;
  logic                     ds_q;
  logic                     out_load;

  // shared units
  logic [ANG_W-1:0] angle;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;
  logic [MUL_P_W-1:0] prod;

  // per-step datapath values
  logic [14:0]      z_mir, z_new;
  logic [14:0]      inner;
  logic [15:0]      mid;
  logic [14:0]      s_mag;
  logic [16:0]      rnd, rnd_neg;
  logic [REF_W-1:0] ref_pos, ref_neg;
  logic [16:0]      diff, diff_abs;
  logic [LIM_W-1:0] pm, pc, cmp_full;
  logic             over;

  cpwm_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (out_load),
    .angle_o (angle)
  );

  cpwm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign prod = mul_rsp.prod;

  always_comb begin
    // quadrant fold: odd quadrants mirror z about a quarter turn
    z_mir = 15'd16384 - {1'b0, angle[13:0]};
    z_new = angle[14] ? z_mir : {1'b0, angle[13:0]};

    inner = 15'(SIN_B) - prod[28:14];
    mid   = 16'(SIN_A) - {1'b0, prod[28:14]};
    s_mag = (prod[29:14] > 16'd32767) ? 15'h7fff : prod[28:14];

    // >>30 with rounding half away from zero, sign applied after
    rnd     = {1'b0, prod[45:30]} + {16'b0, prod[29]};
    rnd_neg = 17'd0 - rnd;
    ref_pos = (rnd > 17'd32767) ? 16'h7fff : rnd[15:0];
    ref_neg = (rnd > 17'd32768) ? 16'h8000 : rnd_neg[15:0];

    diff     = {ref_q[REF_W-1], ref_q} - {meas_q[MEAS_W-1], meas_q};
    diff_abs = diff[16] ? (17'd0 - diff) : diff;

    // clamp the correction magnitude, then offset by half the range
    pm       = prod[LIM_W-1:0];
    over     = pm > CLAMP_LIM;
    pc       = over ? CLAMP_LIM : pm;
    cmp_full = dneg_q ? (CLAMP_LIM - pc) : (CLAMP_LIM + pc);
  end

  always_comb begin
    state_d = state_q;
    meas_d  = meas_q;
    sneg_d  = sneg_q;
    z_d     = z_q;
    z2_d    = z2_q;
    ref_d   = ref_q;
    dneg_d  = dneg_q;
    cmp_d   = cmp_q;
    sat_d   = sat_q;
    mul_req = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          meas_d        = measured_current_i;
          sneg_d        = angle[15];
          z_d           = z_new;
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(z_new);
          mul_req.b     = MUL_B_W'(z_new);
          state_d       = S_ZSQ;
        end
      end
      S_ZSQ: begin
        if (mul_rsp.done) begin
          z2_d          = prod[28:14];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(SIN_C);
          mul_req.b     = MUL_B_W'(prod[28:14]);
          state_d       = S_CZ;
        end
      end
      S_CZ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(inner);
          mul_req.b     = MUL_B_W'(z2_q);
          state_d       = S_IZ;
        end
      end
      S_IZ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(mid);
          mul_req.b     = MUL_B_W'(z_q);
          state_d       = S_MZ;
        end
      end
      S_MZ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(s_mag);
          mul_req.b     = MUL_B_W'(amp_q);
          state_d       = S_SA;
        end
      end
      S_SA: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = prod[MUL_A_W-1:0];
          mul_req.b     = MUL_B_W'(SQRT2_Q15);
          state_d       = S_RT2;
        end
      end
      S_RT2: begin
        if (mul_rsp.done) begin
          ref_d   = sneg_q ? ref_neg : ref_pos;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dneg_d        = diff[16];
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(diff_abs[15:0]);
        mul_req.b     = MUL_B_W'(gain_q);
        state_d       = S_GAIN;
      end
      S_GAIN: begin
        if (mul_rsp.done) begin
          cmp_d   = cmp_full[CMP_W+10:11];
          sat_d   = over;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      amp_q   <= '0;
      gain_q  <= GAIN_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AMP:  amp_q  <= cfg_data_i[AMP_W-1:0];
          REG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
    sneg_q <= sneg_d;
    z_q    <= z_d;
    z2_q   <= z2_d;
    ref_q  <= ref_d;
    dneg_q <= dneg_d;
    cmp_q  <= cmp_d;
    sat_q  <= sat_d;
    if (out_load) begin
      cv_q <= cmp_q;
      rc_q <= ref_q;
      ds_q <= sat_q;
    end
  end

  assign out_valid_o         = ov_q;
  assign compare_value_o     = cv_q;
  assign reference_current_o = rc_q;
  assign drive_saturated_o   = ds_q;

endmodule

`default_nettype wire

[rtl/cpwm_chk.sv]
// port-level checker for the sine current loop, bound to the top level
`default_nettype none

module cpwm_chk import cpwm_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [CMP_W-1:0] compare_value_o,
  input wire logic             drive_saturated_o
);

  // a waiting result beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(compare_value_o))
    else $error("result beat changed while stalled");

  // compare value never leaves the pwm range
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> compare_value_o <= CMP_TOP)
    else $error("compare value above range");

  // a clamped correction sits at one of the two limits
  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_saturated_o |->
      compare_value_o == '0 || compare_value_o == CMP_HI)
    else $error("saturation flag without limit value");

  // one sample at a time: the block is busy right after taking a beat
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is in work");

endmodule

bind sine_ref_current_loop_pwm cpwm_chk u_cpwm_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .compare_value_o   (compare_value_o),
  .drive_saturated_o (drive_saturated_o)
);

`default_nettype wire
